### rtl/hsv_pan_sharpen_eight_band_core_macros.svh
// Assertion macros for the eight-band pan sharpening core
`ifndef HSV_PAN_SHARPEN_EIGHT_BAND_CORE_MACROS_SVH
`define HSV_PAN_SHARPEN_EIGHT_BAND_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HSVPS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define HSVPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HSVPS_ASSERT_ALWAYS(lbl, expr, msg)
`define HSVPS_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

### rtl/hsvps_pkg.sv
// Types and constants of the eight-band pan sharpening core
`timescale 1ns / 1ps
`default_nettype none
package hsvps_pkg;

    localparam int LANES  = 8;
    localparam int QBITS  = 17;
    localparam int DBITS  = 16;
    localparam int NBITS  = 32;
    localparam int LAT    = QBITS + 4;

    typedef struct packed {
        logic signed [15:0] band_0;
        logic signed [15:0] band_1;
        logic signed [15:0] band_2;
        logic signed [15:0] band_3;
        logic signed [15:0] band_4;
        logic signed [15:0] band_5;
        logic signed [15:0] band_6;
        logic signed [15:0] band_7;
        logic signed [15:0] pan_level;
    } pixel_t;

    typedef struct packed {
        logic signed [15:0] out_0;
        logic signed [15:0] out_1;
        logic signed [15:0] out_2;
        logic signed [15:0] out_3;
        logic signed [15:0] out_4;
        logic signed [15:0] out_5;
        logic signed [15:0] out_6;
        logic signed [15:0] out_7;
    } result_t;

    // triple of each band: 0 = (7,5,3), 1 = (6,2,0), 2 = (4,2,1)
    function automatic logic [1:0] lane_triple(input int lane);
        logic [1:0] t;
        case (lane)
            3, 5, 7: t = 2'd0;
            0, 6:    t = 2'd1;
            default: t = 2'd2;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

### rtl/hsv_pan_sharpen_eight_band_core.sv
// Top level of the eight-band pan sharpening core
// One pixel may be started in every cycle; busy is always low. The result
// appears on result with done high after a three-stage front end (clamp and
// maximum, multiply, rounding offset), a 17-stage restoring divider with one
// quotient bit per stage, and an output register. Results cannot be held off
// and must be taken when done is high.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_pan_sharpen_eight_band_core_macros.svh"
module hsv_pan_sharpen_eight_band_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire hsvps_pkg::pixel_t  pixel,
    output logic                    busy,
    output logic                    done,
    output hsvps_pkg::result_t      result
);

    localparam int LANES = hsvps_pkg::LANES;
    localparam int QBITS = hsvps_pkg::QBITS;
    localparam int DBITS = hsvps_pkg::DBITS;
    localparam int NBITS = hsvps_pkg::NBITS;
    localparam int LAT   = hsvps_pkg::LAT;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic signed [15:0] band_in [LANES];
    logic [14:0]        clamp_in [LANES];
    logic [14:0]        max_in [3];

    logic [14:0]        band_reg [LANES];
    logic [14:0]        max_reg [3];
    logic signed [15:0] pan0_reg;

    logic signed [31:0] prod_reg [LANES];
    logic [14:0]        m1_reg [LANES];
    logic signed [15:0] pan1_reg;

    logic [16:0]        rem_reg [0:QBITS][LANES];
    logic [16:0]        ql_reg  [0:QBITS][LANES];
    logic [DBITS-1:0]   d_reg   [0:QBITS][LANES];
    logic               neg_reg [0:QBITS][LANES];
    logic               zero_reg [0:QBITS][LANES];
    logic signed [15:0] pan_reg [0:QBITS];

    logic signed [15:0] res_next [LANES];

    assign busy = 1'b0;

    always_comb
    begin
        band_in[0] = pixel.band_0;
        band_in[1] = pixel.band_1;
        band_in[2] = pixel.band_2;
        band_in[3] = pixel.band_3;
        band_in[4] = pixel.band_4;
        band_in[5] = pixel.band_5;
        band_in[6] = pixel.band_6;
        band_in[7] = pixel.band_7;
        for (int i = 0; i < LANES; i++)
        begin
            clamp_in[i] = band_in[i][15] ? 15'd0 : band_in[i][14:0];
        end
        max_in[0] = clamp_in[7];
        if (clamp_in[5] > max_in[0]) max_in[0] = clamp_in[5];
        if (clamp_in[3] > max_in[0]) max_in[0] = clamp_in[3];
        max_in[1] = clamp_in[6];
        if (clamp_in[2] > max_in[1]) max_in[1] = clamp_in[2];
        if (clamp_in[0] > max_in[1]) max_in[1] = clamp_in[0];
        max_in[2] = clamp_in[4];
        if (clamp_in[2] > max_in[2]) max_in[2] = clamp_in[2];
        if (clamp_in[1] > max_in[2]) max_in[2] = clamp_in[1];
    end

    assign vld_next = {vld_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // front end: clamp and maximum, product, rounding offset and sign fold
    always_ff @(posedge clk)
    begin
        band_reg <= clamp_in;
        max_reg  <= max_in;
        pan0_reg <= pixel.pan_level;
        for (int i = 0; i < LANES; i++)
        begin
            prod_reg[i] <= pan0_reg * $signed({1'b0, band_reg[i]});
            m1_reg[i]   <= max_reg[hsvps_pkg::lane_triple(i)];
        end
        pan1_reg   <= pan0_reg;
        pan_reg[0] <= pan1_reg;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_fold
        logic signed [32:0]  num;
        logic [NBITS-1:0]    mag;
        logic [DBITS-1:0]    dval;
        always_comb
        begin
            dval = {m1_reg[l], 1'b0};
            num  = {prod_reg[l], 1'b0} + $signed({18'd0, m1_reg[l]}) - 33'sd1;
            if (num[32])
                mag = NBITS'(-num) + NBITS'(dval) - NBITS'(1);
            else
                mag = num[NBITS-1:0];
        end
        always_ff @(posedge clk)
        begin
            rem_reg[0][l]  <= {2'b00, mag[NBITS-1:QBITS]};
            ql_reg[0][l]   <= mag[QBITS-1:0];
            d_reg[0][l]    <= dval;
            neg_reg[0][l]  <= num[32];
            zero_reg[0][l] <= (m1_reg[l] == 15'd0);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QBITS; k++) begin : g_div
        always_ff @(posedge clk)
        begin
            pan_reg[k+1] <= pan_reg[k];
        end
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [16:0] trial;
            logic        ge;
            always_comb
            begin
                trial = {rem_reg[k][l][15:0], ql_reg[k][l][16]};
                ge    = (trial >= {1'b0, d_reg[k][l]});
            end
            always_ff @(posedge clk)
            begin
                rem_reg[k+1][l]  <= ge ? (trial - {1'b0, d_reg[k][l]}) : trial;
                ql_reg[k+1][l]   <= {ql_reg[k][l][15:0], ge};
                d_reg[k+1][l]    <= d_reg[k][l];
                neg_reg[k+1][l]  <= neg_reg[k][l];
                zero_reg[k+1][l] <= zero_reg[k][l];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (zero_reg[QBITS][i])
                res_next[i] = pan_reg[QBITS];
            else if (neg_reg[QBITS][i])
                res_next[i] = 16'(-ql_reg[QBITS][i]);
            else
                res_next[i] = ql_reg[QBITS][i][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result.out_0 <= res_next[0];
        result.out_1 <= res_next[1];
        result.out_2 <= res_next[2];
        result.out_3 <= res_next[3];
        result.out_4 <= res_next[4];
        result.out_5 <= res_next[5];
        result.out_6 <= res_next[6];
        result.out_7 <= res_next[7];
    end

    assign done = vld_reg[LAT-1];

    `HSVPS_ASSERT_ALWAYS(a_never_busy, !busy, "core reported busy")
    `HSVPS_ASSERT_IMPLY(a_done_latency, done, $past(start, LAT), "result without transfer")
    for (genvar l = 0; l < LANES; l++) begin : g_chk
        logic chk_en;
        logic rem_ok;
        assign chk_en = vld_reg[LAT-2] && !zero_reg[QBITS][l];
        assign rem_ok = rem_reg[QBITS][l] < {1'b0, d_reg[QBITS][l]};
        `HSVPS_ASSERT_IMPLY(a_rem_bound, chk_en, rem_ok, "divider remainder out of range")
    end

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench of the eight-band pan sharpening core
`timescale 1ns / 1ps
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 1450;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    hsvps_pkg::pixel_t   pixel = '0;
    logic                busy;
    logic                done;
    hsvps_pkg::result_t  result;

    hsvps_pkg::result_t sharpened_q[$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    int      send_idle_pct = 17;

    typedef struct {
        hsvps_pkg::pixel_t  px;
        logic               typed;
        hsvps_pkg::result_t res;
    } pixel_row_t;

    pixel_row_t stim_rows[$];

    hsv_pan_sharpen_eight_band_core i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .pixel  (pixel),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [15:0] scale_channel(input logic signed [15:0] pan,
                                                          input longint c,
                                                          input longint m);
        longint num;
        longint den;
        longint q;
        if (m == 0)
            return pan;
        num = 2 * longint'(pan) * c + m - 1;
        den = 2 * m;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q[15:0];
    endfunction

    function automatic longint floor_zero(input logic signed [15:0] v);
        return (v < 0) ? 0 : longint'(v);
    endfunction

    function automatic hsvps_pkg::result_t sharpen_pixel(input hsvps_pkg::pixel_t p);
        hsvps_pkg::result_t r;
        longint b[8];
        longint m;
        b[0] = floor_zero(p.band_0);
        b[1] = floor_zero(p.band_1);
        b[2] = floor_zero(p.band_2);
        b[3] = floor_zero(p.band_3);
        b[4] = floor_zero(p.band_4);
        b[5] = floor_zero(p.band_5);
        b[6] = floor_zero(p.band_6);
        b[7] = floor_zero(p.band_7);
        m = b[7] > b[5] ? b[7] : b[5];
        m = m > b[3] ? m : b[3];
        r.out_7 = scale_channel(p.pan_level, b[7], m);
        r.out_5 = scale_channel(p.pan_level, b[5], m);
        r.out_3 = scale_channel(p.pan_level, b[3], m);
        m = b[6] > b[2] ? b[6] : b[2];
        m = m > b[0] ? m : b[0];
        r.out_6 = scale_channel(p.pan_level, b[6], m);
        r.out_0 = scale_channel(p.pan_level, b[0], m);
        m = b[4] > b[2] ? b[4] : b[2];
        m = m > b[1] ? m : b[1];
        r.out_4 = scale_channel(p.pan_level, b[4], m);
        r.out_2 = scale_channel(p.pan_level, b[2], m);
        r.out_1 = scale_channel(p.pan_level, b[1], m);
        return r;
    endfunction

    function automatic hsvps_pkg::pixel_t make_pixel(input int b0, input int b1, input int b2,
                                                     input int b3, input int b4, input int b5,
                                                     input int b6, input int b7,
                                                     input int pan);
        hsvps_pkg::pixel_t p;
        p.band_0 = b0[15:0];
        p.band_1 = b1[15:0];
        p.band_2 = b2[15:0];
        p.band_3 = b3[15:0];
        p.band_4 = b4[15:0];
        p.band_5 = b5[15:0];
        p.band_6 = b6[15:0];
        p.band_7 = b7[15:0];
        p.pan_level = pan[15:0];
        return p;
    endfunction

    function automatic hsvps_pkg::result_t all_outputs(input int v);
        hsvps_pkg::result_t r;
        r = {8{v[15:0]}};
        return r;
    endfunction

    function automatic logic [15:0] random_band();
        case ($urandom_range(0, 5))
            0:       return 16'(-$urandom_range(1, 32768));
            1:       return 16'($urandom_range(0, 15));
            2:       return 16'h7fff - 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic hsvps_pkg::pixel_t random_pixel();
        hsvps_pkg::pixel_t p;
        p = '0;
        if ($urandom_range(0, 7) == 0)
            p = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        if ($urandom_range(0, 7) != 0)
        begin
            p.band_0 = random_band();
            p.band_1 = random_band();
            p.band_2 = random_band();
            p.band_3 = random_band();
            p.band_4 = random_band();
            p.band_5 = random_band();
            p.band_6 = random_band();
            p.band_7 = random_band();
            p.pan_level = $urandom_range(0, 3) == 0 ? 16'h8000 : 16'($urandom);
        end
        return p;
    endfunction

    task automatic add_row(input hsvps_pkg::pixel_t p, input logic typed,
                           input hsvps_pkg::result_t r);
        pixel_row_t row;
        row.px = p;
        row.typed = typed;
        row.res = r;
        stim_rows.push_back(row);
    endtask

    task automatic send_pixel(input hsvps_pkg::pixel_t p, input logic typed,
                              input hsvps_pkg::result_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sharpened_q.push_back(typed ? r : sharpen_pixel(p));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        hsvps_pkg::result_t want;
        if (rst_n && done)
        begin
            if (sharpened_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = sharpened_q.pop_front();
                if (result !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h actual %h", want, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        // extremes, black, gray, negative pan, exact halves
        add_row(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 32767), 1'b1, all_outputs(32767));
        add_row(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, -32768), 1'b1, all_outputs(-32768));
        add_row(make_pixel(-32768, -1, -32768, -5, -1, -32768, -2, -32768, 1234), 1'b1,
                all_outputs(1234));
        add_row(make_pixel(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, -32768),
                1'b1, all_outputs(-32768));
        add_row(make_pixel(9, 9, 9, 9, 9, 9, 9, 9, -7), 1'b1, all_outputs(-7));
        add_row(make_pixel(5, 5, 5, 5, 5, 5, 5, 5, 0), 1'b1, all_outputs(0));
        add_row(make_pixel(1, 2, 2, 1, 2, 2, 2, 2, 3), 1'b0, '0);
        add_row(make_pixel(1, 2, 2, 1, 2, 2, 2, 2, -3), 1'b0, '0);
        add_row(make_pixel(1, 32767, 0, 1, 0, 0, 32767, 32767, 32767), 1'b0, '0);
        add_row(make_pixel(1, 32767, 0, 1, 0, 0, 32767, 32767, -32768), 1'b0, '0);
        add_row(make_pixel(-1, 100, 200, 300, -400, 500, 600, 700, -1), 1'b0, '0);
        add_row(make_pixel(32767, 0, 1, 0, 1, 32767, 0, 0, 32767), 1'b0, '0);
        add_row(make_pixel(3, 1, 2, 3, 1, 2, 3, 1, 1), 1'b0, '0);
        add_row(make_pixel(3, 1, 2, 3, 1, 2, 3, 1, -1), 1'b0, '0);
        add_row(make_pixel(0, 0, 7, 0, 0, 0, 0, 4, 16383), 1'b0, '0);
        add_row(make_pixel(16384, 21845, 10922, 32766, 1, 2, 32766, 16383, -32767), 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
            send_pixel(stim_rows[i].px, stim_rows[i].typed, stim_rows[i].res);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 54 : 0;
            repeat (RANDOM_PIXELS / 3)
                send_pixel(random_pixel(), 1'b0, '0);
        end
        start <= 1'b0;

        while (sharpened_q.size() != 0)
            @(posedge clk);
        repeat (hsvps_pkg::LAT + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
